@@ sv/dhfk_pkg.sv @@
// Shared constants, types and link tables for the DH forward kinematics block.
`timescale 1ns / 1ps
package dhfk_pkg;

  localparam int NUM_JOINTS     = 7;
  localparam int NUM_LINKS      = NUM_JOINTS + 1;
  localparam int ANGLE_W        = 16;
  localparam int DEF_ANGLE_BITS = 16;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int IQ             = 30;
  localparam int CORDIC_STEPS   = 30;
  localparam int ROT_QW         = 32;  // Q30 rotation entry
  localparam int POS_QW         = 34;  // Q30 position entry
  localparam int Z_W            = 32;
  localparam int XY_W           = 34;

  localparam logic signed [XY_W-1:0]   CORDIC_K = 34'sd652032874;
  localparam logic signed [ROT_QW-1:0] ONE_Q    = 32'sd1073741824;

  localparam logic signed [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
    32'sd21354465, 32'sd10679838, 32'sd5340245, 32'sd2670163, 32'sd1335087,
    32'sd667544, 32'sd333772, 32'sd166886, 32'sd83443, 32'sd41721,
    32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
    32'sd652, 32'sd326, 32'sd163, 32'sd81, 32'sd41,
    32'sd20, 32'sd10, 32'sd5, 32'sd3, 32'sd1
  };

  typedef enum logic [1:0] {
    TW_ZERO = 2'd0,
    TW_POS  = 2'd1,
    TW_NEG  = 2'd2
  } twist_t;

  localparam twist_t LINK_TWIST [NUM_LINKS] = '{
    TW_ZERO, TW_NEG, TW_POS, TW_POS, TW_NEG, TW_POS, TW_POS, TW_ZERO
  };
  localparam logic signed [31:0] LINK_A [NUM_LINKS] = '{
    32'sd0, 32'sd0, 32'sd0, 32'sd88583700, -32'sd88583700, 32'sd0, 32'sd94489281, 32'sd0
  };
  localparam logic signed [31:0] LINK_D [NUM_LINKS] = '{
    32'sd357556027, 32'sd0, 32'sd339302416, 32'sd0, 32'sd412316860, 32'sd0, 32'sd0,
    32'sd114890375
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             quad;
  } cordic_lane_t;

endpackage

@@ sv/dhfk_if.sv @@
// Valid/ready channel interfaces for joint angles and pose results.
`timescale 1ns / 1ps
interface dhfk_in_if;
  logic                        valid;
  logic                        ready;
  logic [dhfk_pkg::ANGLE_W-1:0] joint_angle_1;
  logic [dhfk_pkg::ANGLE_W-1:0] joint_angle_2;
  logic [dhfk_pkg::ANGLE_W-1:0] joint_angle_3;
  logic [dhfk_pkg::ANGLE_W-1:0] joint_angle_4;
  logic [dhfk_pkg::ANGLE_W-1:0] joint_angle_5;
  logic [dhfk_pkg::ANGLE_W-1:0] joint_angle_6;
  logic [dhfk_pkg::ANGLE_W-1:0] joint_angle_7;
  modport source (output valid, joint_angle_1, joint_angle_2, joint_angle_3, joint_angle_4,
                  joint_angle_5, joint_angle_6, joint_angle_7, input ready);
  modport sink   (input valid, joint_angle_1, joint_angle_2, joint_angle_3, joint_angle_4,
                  joint_angle_5, joint_angle_6, joint_angle_7, output ready);
endinterface

interface dhfk_out_if #(parameter int FRAC_BITS = dhfk_pkg::DEF_FRAC_BITS);
  localparam int RW = FRAC_BITS + 2;
  localparam int PW = FRAC_BITS + 3;
  logic                 valid;
  logic                 ready;
  logic signed [RW-1:0] rot_r0_c0;
  logic signed [RW-1:0] rot_r0_c1;
  logic signed [RW-1:0] rot_r0_c2;
  logic signed [PW-1:0] pos_x;
  logic signed [RW-1:0] rot_r1_c0;
  logic signed [RW-1:0] rot_r1_c1;
  logic signed [RW-1:0] rot_r1_c2;
  logic signed [PW-1:0] pos_y;
  logic signed [RW-1:0] rot_r2_c0;
  logic signed [RW-1:0] rot_r2_c1;
  logic signed [RW-1:0] rot_r2_c2;
  logic signed [PW-1:0] pos_z;
  modport source (output valid, rot_r0_c0, rot_r0_c1, rot_r0_c2, pos_x, rot_r1_c0, rot_r1_c1,
                  rot_r1_c2, pos_y, rot_r2_c0, rot_r2_c1, rot_r2_c2, pos_z, input ready);
  modport sink   (input valid, rot_r0_c0, rot_r0_c1, rot_r0_c2, pos_x, rot_r1_c0, rot_r1_c1,
                  rot_r1_c2, pos_y, rot_r2_c0, rot_r2_c1, rot_r2_c2, pos_z, output ready);
endinterface

@@ sv/dhfk_cordic_cell.sv @@
// One CORDIC rotation step applied to all joint lanes, registered.
`timescale 1ns / 1ps
module dhfk_cordic_cell #(
  parameter int                     STEP = 0,
  parameter logic signed [31:0]     ATAN = 32'sd0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  dhfk_pkg::cordic_lane_t     lane_i [dhfk_pkg::NUM_JOINTS],
  output logic                       vld_o,
  output dhfk_pkg::cordic_lane_t     lane_o [dhfk_pkg::NUM_JOINTS]
);

  logic                   vld_r;
  dhfk_pkg::cordic_lane_t lane_r   [dhfk_pkg::NUM_JOINTS];
  dhfk_pkg::cordic_lane_t lane_nxt [dhfk_pkg::NUM_JOINTS];

  always_comb begin
    for (int j = 0; j < dhfk_pkg::NUM_JOINTS; j++) begin
      lane_nxt[j].quad = lane_i[j].quad;
      if (!lane_i[j].z[dhfk_pkg::Z_W-1]) begin
        lane_nxt[j].x = lane_i[j].x - (lane_i[j].y >>> STEP);
        lane_nxt[j].y = lane_i[j].y + (lane_i[j].x >>> STEP);
        lane_nxt[j].z = lane_i[j].z - ATAN;
      end else begin
        lane_nxt[j].x = lane_i[j].x + (lane_i[j].y >>> STEP);
        lane_nxt[j].y = lane_i[j].y - (lane_i[j].x >>> STEP);
        lane_nxt[j].z = lane_i[j].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign lane_o = lane_r;

endmodule

@@ sv/dhfk_link_cell.sv @@
// Right-multiplies the running pose by one modified DH link; two register stages.
`timescale 1ns / 1ps
module dhfk_link_cell #(
  parameter dhfk_pkg::twist_t   TWIST = dhfk_pkg::TW_ZERO,
  parameter logic signed [31:0] LA    = 32'sd0,
  parameter logic signed [31:0] LD    = 32'sd0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_i,
  input  logic signed [dhfk_pkg::ROT_QW-1:0]  rot_i [3][3],
  input  logic signed [dhfk_pkg::POS_QW-1:0]  pos_i [3],
  input  logic signed [dhfk_pkg::ROT_QW-1:0]  lcos_i,
  input  logic signed [dhfk_pkg::ROT_QW-1:0]  lsin_i,
  input  logic signed [dhfk_pkg::ROT_QW-1:0]  cos_i [dhfk_pkg::NUM_JOINTS],
  input  logic signed [dhfk_pkg::ROT_QW-1:0]  sin_i [dhfk_pkg::NUM_JOINTS],
  output logic                                vld_o,
  output logic signed [dhfk_pkg::ROT_QW-1:0]  rot_o [3][3],
  output logic signed [dhfk_pkg::POS_QW-1:0]  pos_o [3],
  output logic signed [dhfk_pkg::ROT_QW-1:0]  cos_o [dhfk_pkg::NUM_JOINTS],
  output logic signed [dhfk_pkg::ROT_QW-1:0]  sin_o [dhfk_pkg::NUM_JOINTS]
);

  localparam int RW = dhfk_pkg::ROT_QW;
  localparam int PW = dhfk_pkg::POS_QW;
  localparam int SW = 68;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (dhfk_pkg::IQ - 1);

  // stage 1: products
  logic                 vld1_r;
  logic signed [63:0]   p0c_r [3], p1s_r [3], p0s_r [3], p1c_r [3], pa_r [3], pe_r [3];
  logic signed [RW-1:0] e_r [3];
  logic signed [PW-1:0] pos1_r [3];
  logic signed [RW-1:0] cos1_r [dhfk_pkg::NUM_JOINTS], sin1_r [dhfk_pkg::NUM_JOINTS];
  logic signed [RW-1:0] b_w [3], e_w [3];

  // stage 2: sums and rounding
  logic                 vld2_r;
  logic signed [RW-1:0] rot_r [3][3], rot_nxt [3][3];
  logic signed [PW-1:0] pos_r [3], pos_nxt [3];
  logic signed [RW-1:0] cos2_r [dhfk_pkg::NUM_JOINTS], sin2_r [dhfk_pkg::NUM_JOINTS];
  logic signed [SW-1:0] s0, s1, s3;

  // b feeds the angle columns, e is the column that the twist moves into column 2
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      case (TWIST)
        dhfk_pkg::TW_ZERO: begin
          b_w[r] = rot_i[r][1];
          e_w[r] = rot_i[r][2];
        end
        dhfk_pkg::TW_POS: begin
          b_w[r] = rot_i[r][2];
          e_w[r] = -rot_i[r][1];
        end
        dhfk_pkg::TW_NEG: begin
          b_w[r] = -rot_i[r][2];
          e_w[r] = rot_i[r][1];
        end
        default: begin
          b_w[r] = rot_i[r][1];
          e_w[r] = rot_i[r][2];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        p0c_r[r]  <= rot_i[r][0] * lcos_i;
        p1s_r[r]  <= b_w[r] * lsin_i;
        p0s_r[r]  <= rot_i[r][0] * lsin_i;
        p1c_r[r]  <= b_w[r] * lcos_i;
        pa_r[r]   <= rot_i[r][0] * LA;
        pe_r[r]   <= e_w[r] * LD;
        e_r[r]    <= e_w[r];
        pos1_r[r] <= pos_i[r];
      end
      cos1_r <= cos_i;
      sin1_r <= sin_i;
    end
  end

  always_comb begin
    s0 = '0;
    s1 = '0;
    s3 = '0;
    for (int r = 0; r < 3; r++) begin
      s0 = SW'(p0c_r[r]) + SW'(p1s_r[r]) + HALF;
      s1 = SW'(p1c_r[r]) - SW'(p0s_r[r]) + HALF;
      s3 = SW'(pa_r[r]) + SW'(pe_r[r]) + (SW'(pos1_r[r]) <<< dhfk_pkg::IQ) + HALF;
      rot_nxt[r][0] = s0[dhfk_pkg::IQ +: RW];
      rot_nxt[r][1] = s1[dhfk_pkg::IQ +: RW];
      rot_nxt[r][2] = e_r[r];
      pos_nxt[r]    = s3[dhfk_pkg::IQ +: PW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r  <= rot_nxt;
      pos_r  <= pos_nxt;
      cos2_r <= cos1_r;
      sin2_r <= sin1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  assign vld_o = vld2_r;
  assign rot_o = rot_r;
  assign pos_o = pos_r;
  assign cos_o = cos2_r;
  assign sin_o = sin2_r;

endmodule

@@ sv/dh_forward_kinematics_7dof_top.sv @@
// Top level: seven-joint modified DH forward kinematics, fully pipelined.
// Pipeline: 1 angle prep, 30 CORDIC cells, 1 sine/cosine fixup, 7 link cells of 2 stages,
//   1 output round/saturate register.
// Throughput: one beat per cycle; the whole pipe holds only while a result beat
//   waits at the output and out ready is low.
// Reset: synchronous active-low rst_n clears every stage valid; data is not reset.
`timescale 1ns / 1ps
module dh_forward_kinematics_7dof_top #(
  parameter int ANGLE_BITS = dhfk_pkg::DEF_ANGLE_BITS,
  parameter int FRAC_BITS  = dhfk_pkg::DEF_FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  dhfk_in_if.sink        in_if,
  dhfk_out_if.source     out_if
);

  localparam int NJ = dhfk_pkg::NUM_JOINTS;
  localparam int NS = dhfk_pkg::CORDIC_STEPS;
  localparam int RW = dhfk_pkg::ROT_QW;
  localparam int PW = dhfk_pkg::POS_QW;
  localparam int ORW = FRAC_BITS + 2;
  localparam int OPW = FRAC_BITS + 3;
  localparam int SH = dhfk_pkg::IQ - FRAC_BITS;
  localparam int VW = 40;
  localparam logic signed [VW-1:0] OHALF   = (SH == 0) ? VW'(0) : (VW'(1) <<< (SH - 1));
  localparam logic signed [VW-1:0] ROT_LIM = VW'(1) <<< FRAC_BITS;
  localparam logic signed [VW-1:0] POS_LIM = VW'(2) <<< FRAC_BITS;
  localparam logic [31:0] QUART = 32'h2000_0000;

  logic en;

  // ---------------- angle prep ----------------
  logic [dhfk_pkg::ANGLE_W-1:0] ang [NJ];
  logic [ANGLE_BITS-1:0]        ang_ab [NJ];
  logic [31:0]                  turn [NJ], ushift [NJ];
  dhfk_pkg::cordic_lane_t       prep_nxt [NJ];
  dhfk_pkg::cordic_lane_t       cl [NS+1][NJ];
  logic                         cv [NS+1];
  logic                         prep_vld_r;
  dhfk_pkg::cordic_lane_t       prep_r [NJ];

  assign ang[0] = in_if.joint_angle_1;
  assign ang[1] = in_if.joint_angle_2;
  assign ang[2] = in_if.joint_angle_3;
  assign ang[3] = in_if.joint_angle_4;
  assign ang[4] = in_if.joint_angle_5;
  assign ang[5] = in_if.joint_angle_6;
  assign ang[6] = in_if.joint_angle_7;

  always_comb begin
    for (int j = 0; j < NJ; j++) begin
      ang_ab[j] = ANGLE_BITS'(ang[j]);
      turn[j]   = 32'(ang_ab[j]) << (32 - ANGLE_BITS);
      ushift[j] = turn[j] + QUART;
      prep_nxt[j].quad = ushift[j][31:30];
      prep_nxt[j].z    = $signed({2'b00, ushift[j][29:0]}) - $signed(QUART);
      prep_nxt[j].x    = dhfk_pkg::CORDIC_K;
      prep_nxt[j].y    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (en) begin
      prep_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign cl[0] = prep_r;
  assign cv[0] = prep_vld_r;

  // ---------------- CORDIC chain ----------------
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    dhfk_cordic_cell #(
      .STEP (i),
      .ATAN (dhfk_pkg::ATAN_TURNS[i])
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (cv[i]),
      .lane_i (cl[i]),
      .vld_o  (cv[i+1]),
      .lane_o (cl[i+1])
    );
  end

  // ---------------- saturate and quadrant fixup ----------------
  logic                 cs_vld_r;
  logic signed [RW-1:0] cos_r [NJ], sin_r [NJ], cos_nxt [NJ], sin_nxt [NJ];
  logic signed [RW-1:0] xc, yc;

  always_comb begin
    xc = '0;
    yc = '0;
    for (int j = 0; j < NJ; j++) begin
      if (cl[NS][j].x > dhfk_pkg::XY_W'(dhfk_pkg::ONE_Q))        xc = dhfk_pkg::ONE_Q;
      else if (cl[NS][j].x < -dhfk_pkg::XY_W'(dhfk_pkg::ONE_Q)) xc = -dhfk_pkg::ONE_Q;
      else                                                       xc = RW'(cl[NS][j].x);
      if (cl[NS][j].y > dhfk_pkg::XY_W'(dhfk_pkg::ONE_Q))        yc = dhfk_pkg::ONE_Q;
      else if (cl[NS][j].y < -dhfk_pkg::XY_W'(dhfk_pkg::ONE_Q)) yc = -dhfk_pkg::ONE_Q;
      else                                                       yc = RW'(cl[NS][j].y);
      case (cl[NS][j].quad)
        2'd0: begin
          cos_nxt[j] = xc;
          sin_nxt[j] = yc;
        end
        2'd1: begin
          cos_nxt[j] = -yc;
          sin_nxt[j] = xc;
        end
        2'd2: begin
          cos_nxt[j] = -xc;
          sin_nxt[j] = -yc;
        end
        default: begin
          cos_nxt[j] = yc;
          sin_nxt[j] = -xc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_vld_r <= 1'b0;
    end else if (en) begin
      cs_vld_r <= cv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  // ---------------- link chain ----------------
  logic                 ch_vld [NJ+1];
  logic signed [RW-1:0] ch_rot [NJ+1][3][3];
  logic signed [PW-1:0] ch_pos [NJ+1][3];
  logic signed [RW-1:0] ch_cos [NJ+1][NJ];
  logic signed [RW-1:0] ch_sin [NJ+1][NJ];

  // first link taken as is (twist 0)
  always_comb begin
    ch_rot[0][0][0] = cos_r[0];
    ch_rot[0][0][1] = -sin_r[0];
    ch_rot[0][0][2] = '0;
    ch_rot[0][1][0] = sin_r[0];
    ch_rot[0][1][1] = cos_r[0];
    ch_rot[0][1][2] = '0;
    ch_rot[0][2][0] = '0;
    ch_rot[0][2][1] = '0;
    ch_rot[0][2][2] = dhfk_pkg::ONE_Q;
    ch_pos[0][0]    = PW'(dhfk_pkg::LINK_A[0]);
    ch_pos[0][1]    = '0;
    ch_pos[0][2]    = PW'(dhfk_pkg::LINK_D[0]);
  end

  assign ch_vld[0] = cs_vld_r;
  assign ch_cos[0] = cos_r;
  assign ch_sin[0] = sin_r;

  for (genvar k = 1; k <= NJ; k++) begin : g_link
    logic signed [RW-1:0] lc, ls;
    if (k < NJ) begin : g_joint
      assign lc = ch_cos[k-1][k];
      assign ls = ch_sin[k-1][k];
    end else begin : g_flange
      assign lc = dhfk_pkg::ONE_Q;
      assign ls = '0;
    end
    dhfk_link_cell #(
      .TWIST (dhfk_pkg::LINK_TWIST[k]),
      .LA    (dhfk_pkg::LINK_A[k]),
      .LD    (dhfk_pkg::LINK_D[k])
    ) u_link (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (ch_vld[k-1]),
      .rot_i  (ch_rot[k-1]),
      .pos_i  (ch_pos[k-1]),
      .lcos_i (lc),
      .lsin_i (ls),
      .cos_i  (ch_cos[k-1]),
      .sin_i  (ch_sin[k-1]),
      .vld_o  (ch_vld[k]),
      .rot_o  (ch_rot[k]),
      .pos_o  (ch_pos[k]),
      .cos_o  (ch_cos[k]),
      .sin_o  (ch_sin[k])
    );
  end

  // ---------------- output round, saturate, register ----------------
  logic                  out_vld_r;
  logic signed [ORW-1:0] orot_r [3][3], orot_nxt [3][3];
  logic signed [OPW-1:0] opos_r [3], opos_nxt [3];
  logic signed [VW-1:0]  vr, vp;

  always_comb begin
    vr = '0;
    vp = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        vr = (VW'(ch_rot[NJ][r][c]) + OHALF) >>> SH;
        if (vr > ROT_LIM)       vr = ROT_LIM;
        else if (vr < -ROT_LIM) vr = -ROT_LIM;
        orot_nxt[r][c] = ORW'(vr);
      end
      vp = (VW'(ch_pos[NJ][r]) + OHALF) >>> SH;
      if (vp > POS_LIM)       vp = POS_LIM;
      else if (vp < -POS_LIM) vp = -POS_LIM;
      opos_nxt[r] = OPW'(vp);
    end
  end

  assign en = !out_vld_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ch_vld[NJ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      orot_r <= orot_nxt;
      opos_r <= opos_nxt;
    end
  end

  assign in_if.ready      = en;
  assign out_if.valid     = out_vld_r;
  assign out_if.rot_r0_c0 = orot_r[0][0];
  assign out_if.rot_r0_c1 = orot_r[0][1];
  assign out_if.rot_r0_c2 = orot_r[0][2];
  assign out_if.pos_x     = opos_r[0];
  assign out_if.rot_r1_c0 = orot_r[1][0];
  assign out_if.rot_r1_c1 = orot_r[1][1];
  assign out_if.rot_r1_c2 = orot_r[1][2];
  assign out_if.pos_y     = opos_r[1];
  assign out_if.rot_r2_c0 = orot_r[2][0];
  assign out_if.rot_r2_c1 = orot_r[2][1];
  assign out_if.rot_r2_c2 = orot_r[2][2];
  assign out_if.pos_z     = opos_r[2];

  // ---------------- assertions ----------------
  a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(cs_vld_r) && $stable(ch_vld[NJ]) && $stable(prep_vld_r))
    else $error("pipeline moved during stall");

  a_rot_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (VW'(orot_r[0][0]) <= ROT_LIM) && (VW'(orot_r[0][0]) >= -ROT_LIM)
                  && (VW'(orot_r[2][2]) <= ROT_LIM) && (VW'(orot_r[2][2]) >= -ROT_LIM))
    else $error("rotation entry out of range");

  a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (VW'(opos_r[0]) <= POS_LIM) && (VW'(opos_r[0]) >= -POS_LIM)
                  && (VW'(opos_r[2]) <= POS_LIM) && (VW'(opos_r[2]) >= -POS_LIM))
    else $error("position out of range");

  a_cs_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cs_vld_r |-> (cos_r[0] <= dhfk_pkg::ONE_Q) && (cos_r[0] >= -dhfk_pkg::ONE_Q)
                 && (sin_r[0] <= dhfk_pkg::ONE_Q) && (sin_r[0] >= -dhfk_pkg::ONE_Q))
    else $error("sine/cosine beyond unity");

endmodule
